[rtl/core/mtg_pkg.sv]
// ============================================================================
// mtg_pkg: shared types and constants of the MT19937 generator
// Holds the word and index constants of the generator, the input command
// codes, the controller states and the control and status bundles between
// the controller and the datapath.
// ============================================================================
package mtg_pkg;

    // Size of the generator state and the derived index widths.
    localparam int unsigned STATE_WORDS = 624;
    localparam int unsigned MID_DIST    = 397;
    localparam int unsigned IDX_W       = $clog2(STATE_WORDS);
    // The position also holds "twist pending" and "never seeded".
    localparam int unsigned POS_W       = $clog2(STATE_WORDS + 2);
    localparam int unsigned WORD_W      = 32;

    localparam logic [POS_W-1:0] POS_PENDING = POS_W'(STATE_WORDS);
    localparam logic [POS_W-1:0] POS_NEVER   = POS_W'(STATE_WORDS + 1);
    localparam logic [IDX_W-1:0] LAST_WORD   = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0] FAR_OFS     = IDX_W'(MID_DIST);
    localparam logic [IDX_W-1:0] FAR_WRAP    = IDX_W'(STATE_WORDS - MID_DIST);

    localparam logic [WORD_W-1:0] TWIST_MAT    = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [WORD_W-1:0] LCG_MUL      = 32'd69069;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;

    // Input command codes.
    typedef enum logic [1:0] {
        CMD_NEXT = 2'd0,
        CMD_SEED = 2'd1,
        CMD_LOAD = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_TW_PRE,
        ST_TWIST,
        ST_TW_END,
        ST_TEMPER
    } t_state;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SEED_INIT,
        OP_SEED_STEP,
        OP_TW_START,
        OP_TW_STEP,
        OP_TW_END,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic use_default;
    } t_dp_ctrl;

    typedef struct packed {
        logic pos_never;
        logic pos_pending;
        logic idx_ok;
        logic sweep_last;
        logic out_free;
    } t_dp_status;

endpackage

[rtl/core/mtg_ctrl.sv]
// ============================================================================
// mtg_ctrl: controller of the MT19937 generator
// Decodes accepted commands and sequences the seeding sweep, the twist
// sweep and the tempered read through the datapath.
// ============================================================================
module mtg_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [1:0]            i_cmd,
    output logic                  o_ready,
    input  mtg_pkg::t_dp_status   i_status,
    output mtg_pkg::t_dp_ctrl     o_ctrl
);

    mtg_pkg::t_state r_state;
    mtg_pkg::t_state n_state;
    logic            r_want_out;
    logic            n_want_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mtg_pkg::ST_IDLE;
            r_want_out <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_want_out <= n_want_out;
        end
    end

    // Next state.
    always_comb begin
        n_state    = r_state;
        n_want_out = r_want_out;
        unique case (r_state)
            mtg_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_want_out = (i_cmd == mtg_pkg::CMD_NEXT);
                    priority if (i_cmd == mtg_pkg::CMD_NEXT) begin
                        priority if (i_status.pos_never) begin
                            n_state = mtg_pkg::ST_SEED;
                        end else if (i_status.pos_pending) begin
                            n_state = mtg_pkg::ST_TW_PRE;
                        end else begin
                            n_state = mtg_pkg::ST_TEMPER;
                        end
                    end else if (i_cmd == mtg_pkg::CMD_SEED) begin
                        n_state = mtg_pkg::ST_SEED;
                    end else begin
                        n_state = mtg_pkg::ST_IDLE;
                    end
                end
            end
            mtg_pkg::ST_SEED: begin
                if (i_status.sweep_last) begin
                    n_state = r_want_out ? mtg_pkg::ST_TW_PRE : mtg_pkg::ST_IDLE;
                end
            end
            mtg_pkg::ST_TW_PRE: begin
                n_state = mtg_pkg::ST_TWIST;
            end
            mtg_pkg::ST_TWIST: begin
                if (i_status.sweep_last) begin
                    n_state = mtg_pkg::ST_TW_END;
                end
            end
            mtg_pkg::ST_TW_END: begin
                n_state = mtg_pkg::ST_TEMPER;
            end
            mtg_pkg::ST_TEMPER: begin
                if (i_status.out_free) begin
                    n_state = mtg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mtg_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_ready            = 1'b0;
        o_ctrl.op          = mtg_pkg::OP_NONE;
        o_ctrl.use_default = 1'b0;
        unique case (r_state)
            mtg_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    unique case (i_cmd)
                        mtg_pkg::CMD_NEXT: begin
                            if (i_status.pos_never) begin
                                o_ctrl.op          = mtg_pkg::OP_SEED_INIT;
                                o_ctrl.use_default = 1'b1;
                            end
                        end
                        mtg_pkg::CMD_SEED: begin
                            o_ctrl.op = mtg_pkg::OP_SEED_INIT;
                        end
                        mtg_pkg::CMD_LOAD: begin
                            if (i_status.idx_ok) begin
                                o_ctrl.op = mtg_pkg::OP_LOAD;
                            end
                        end
                        default: begin
                            o_ctrl.op = mtg_pkg::OP_NONE;
                        end
                    endcase
                end
            end
            mtg_pkg::ST_SEED:   o_ctrl.op = mtg_pkg::OP_SEED_STEP;
            mtg_pkg::ST_TW_PRE: o_ctrl.op = mtg_pkg::OP_TW_START;
            mtg_pkg::ST_TWIST:  o_ctrl.op = mtg_pkg::OP_TW_STEP;
            mtg_pkg::ST_TW_END: o_ctrl.op = mtg_pkg::OP_TW_END;
            mtg_pkg::ST_TEMPER: begin
                if (i_status.out_free) begin
                    o_ctrl.op = mtg_pkg::OP_OUT;
                end
            end
            default: begin
                o_ctrl.op = mtg_pkg::OP_NONE;
            end
        endcase
    end

endmodule

[rtl/core/mtg_dpath.sv]
// ============================================================================
// mtg_dpath: datapath of the MT19937 generator
// State memory, position counter, seeding multiplier, twist recurrence,
// tempering and the output register.
// ============================================================================
module mtg_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mtg_pkg::t_dp_ctrl            i_ctrl,
    output mtg_pkg::t_dp_status          o_status,
    input  logic [mtg_pkg::WORD_W-1:0]   i_value,
    input  logic [mtg_pkg::IDX_W-1:0]    i_word_index,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [mtg_pkg::WORD_W-1:0]   o_number
);

    localparam int unsigned W  = mtg_pkg::WORD_W;
    localparam int unsigned IW = mtg_pkg::IDX_W;
    localparam int unsigned PW = mtg_pkg::POS_W;

    function automatic logic [W-1:0] f_temper(input logic [W-1:0] x);
        logic [W-1:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
        y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    logic [W-1:0]  r_mem [mtg_pkg::STATE_WORDS];
    logic [W-1:0]  r_rdata;

    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_idx, n_idx;
    logic          r_ph, n_ph;
    logic          r_first, n_first;
    logic [W-1:0]  r_cur, n_cur;
    logic [W-1:0]  r_nxt, n_nxt;
    logic [W-1:0]  r_s, n_s;
    logic [15:0]   r_hi, n_hi;
    logic          r_out_valid, n_out_valid;
    logic [W-1:0]  r_number, n_number;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [IW-1:0] mem_raddr;
    logic [W-1:0]  mem_wdata;

    logic [PW-1:0] idx_prev;
    logic [IW-1:0] idx_lo;
    logic [IW-1:0] nxt_addr;
    logic [IW-1:0] far_addr;
    logic [W-1:0]  lcg;
    logic [W-1:0]  tw_y;
    logic [W-1:0]  tw_word;
    logic          pos_ok;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= mtg_pkg::POS_NEVER;
            r_idx       <= '0;
            r_ph        <= 1'b0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_idx       <= n_idx;
            r_ph        <= n_ph;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_nxt    <= n_nxt;
        r_s      <= n_s;
        r_hi     <= n_hi;
        r_number <= n_number;
    end

    assign idx_prev = r_idx - PW'(1);
    assign idx_lo   = r_idx[IW-1:0];
    assign nxt_addr = (idx_lo == mtg_pkg::LAST_WORD) ? '0 : idx_lo + IW'(1);
    assign far_addr = (idx_lo < mtg_pkg::FAR_WRAP) ? idx_lo + mtg_pkg::FAR_OFS
                                                   : idx_lo - mtg_pkg::FAR_WRAP;
    assign lcg      = W'(r_s * mtg_pkg::LCG_MUL) + W'(1);
    // The word being rewritten supplies its top bit, the following word the rest.
    assign tw_y     = {r_cur[W-1], r_nxt[W-2:0]};
    assign tw_word  = r_rdata ^ (tw_y >> 1) ^ (tw_y[0] ? mtg_pkg::TWIST_MAT : '0);
    assign pos_ok   = (r_pos != mtg_pkg::POS_NEVER) && (r_pos != mtg_pkg::POS_PENDING);

    always_comb begin
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_ph        = r_ph;
        n_first     = r_first;
        n_cur       = r_cur;
        n_nxt       = r_nxt;
        n_s         = r_s;
        n_hi        = r_hi;
        n_out_valid = r_out_valid && !i_ready;
        n_number    = r_number;
        mem_we      = 1'b0;
        mem_waddr   = idx_prev[IW-1:0];
        mem_wdata   = tw_word;
        mem_raddr   = pos_ok ? r_pos[IW-1:0] : '0;
        unique case (i_ctrl.op)
            mtg_pkg::OP_NONE: begin
                n_pos = r_pos;
            end
            mtg_pkg::OP_LOAD: begin
                mem_we    = 1'b1;
                mem_waddr = i_word_index;
                mem_wdata = i_value;
                n_pos     = mtg_pkg::POS_PENDING;
            end
            mtg_pkg::OP_SEED_INIT: begin
                n_s   = i_ctrl.use_default ? mtg_pkg::DEFAULT_SEED : i_value;
                n_idx = '0;
                n_ph  = 1'b0;
            end
            mtg_pkg::OP_SEED_STEP: begin
                n_s = lcg;
                if (!r_ph) begin
                    n_hi = r_s[W-1:16];
                    n_ph = 1'b1;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_lo;
                    mem_wdata = {r_hi, r_s[W-1:16]};
                    n_ph      = 1'b0;
                    n_idx     = r_idx + PW'(1);
                    if (idx_lo == mtg_pkg::LAST_WORD) begin
                        n_pos = mtg_pkg::POS_PENDING;
                    end
                end
            end
            mtg_pkg::OP_TW_START: begin
                mem_raddr = '0;
                n_idx     = '0;
                n_ph      = 1'b0;
                n_first   = 1'b1;
            end
            mtg_pkg::OP_TW_STEP: begin
                if (!r_ph) begin
                    // Read data is the far word of the previous step, or word 0
                    // on the first step.
                    mem_raddr = nxt_addr;
                    if (r_first) begin
                        n_cur = r_rdata;
                    end else begin
                        mem_we = 1'b1;
                        n_cur  = r_nxt;
                    end
                    n_first = 1'b0;
                    n_ph    = 1'b1;
                end else begin
                    mem_raddr = far_addr;
                    n_nxt     = r_rdata;
                    n_ph      = 1'b0;
                    n_idx     = r_idx + PW'(1);
                end
            end
            mtg_pkg::OP_TW_END: begin
                mem_raddr = '0;
                mem_we    = 1'b1;
                n_pos     = '0;
            end
            mtg_pkg::OP_OUT: begin
                n_out_valid = 1'b1;
                n_number    = f_temper(r_rdata);
                n_pos       = r_pos + PW'(1);
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    assign o_status.pos_never   = (r_pos == mtg_pkg::POS_NEVER);
    assign o_status.pos_pending = (r_pos == mtg_pkg::POS_PENDING);
    assign o_status.idx_ok      = (i_word_index < mtg_pkg::POS_PENDING);
    assign o_status.sweep_last  = r_ph && (idx_lo == mtg_pkg::LAST_WORD);
    assign o_status.out_free    = !r_out_valid || i_ready;

    assign o_valid  = r_out_valid;
    assign o_number = r_number;

endmodule

[rtl/core/mersenne_twister_generator.sv]
// ============================================================================
// mersenne_twister_generator: MT19937 32-bit pseudorandom generator
// Top level joining the command controller and the state datapath.
// ============================================================================
// Each input transaction carries a command. Command 0 returns one tempered
// 32-bit number as an output transaction; command 1 reseeds all 624 state
// words from the given value; command 2 writes one raw state word (an index
// of 624 or more is ignored) and schedules a twist before the next number;
// command 3 is ignored. If the state has never been seeded or loaded, the
// first command 0 seeds with 4357 on its own. The state sits in one
// single-port-write, single-port-read memory. Seeding needs two steps of
// the linear congruential multiplier for each word, and a twist needs two
// memory reads for each word. The block takes one transaction at a time,
// but the result sits in an output register, so a following command is
// accepted while an earlier number still waits to be taken. No clearing
// pass follows reset: state words are undefined until seeded or loaded.
// ============================================================================
module mersenne_twister_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_value,
    input  logic [9:0]  i_word_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_number
);

    // Operation issued by the controller each cycle, and the datapath's
    // view of the position, the load index, the sweeps and the output slot.
    mtg_pkg::t_dp_ctrl   ctrl;
    mtg_pkg::t_dp_status status;

    mtg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_cmd    (i_cmd),
        .o_ready  (o_ready),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    mtg_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .o_status     (status),
        .i_value      (i_value),
        .i_word_index (i_word_index),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_number     (o_number)
    );

`ifndef SYNTH
    // A number is only written into the output register when the slot is free.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.op == mtg_pkg::OP_OUT) |-> status.out_free)
        else $error("number written over an untaken result");

    // The close of a twist always leaves a readable position.
    a_twist_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.op == mtg_pkg::OP_TW_END) |=> (!status.pos_never && !status.pos_pending))
        else $error("position not valid after twist");

    // A result appears only as the outcome of a tempered read.
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(ctrl.op == mtg_pkg::OP_OUT))
        else $error("output valid raised without a tempered read");
`endif

endmodule

[tb/mersenne_twister_generator_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// mersenne_twister_generator_tb: self-checking bench for the MT19937 block
// Sends a directed run of commands and then random command sequences. A
// predictor inside the bench keeps its own copy of the 624 state words and
// the position. Every number that the block returns is compared with the
// oldest predicted number.
// ============================================================================
module mersenne_twister_generator_tb;

    localparam logic [31:0] HALF_MASK    = 32'hffff_0000;
    localparam logic [31:0] HI_BIT       = 32'h8000_0000;
    localparam logic [31:0] LO_BITS      = 32'h7fff_ffff;
    localparam int unsigned RANDOM_ITEMS = 1950;
    localparam int unsigned IDLE_PCT     = 34;
    // A seed at the very end keeps the block busy while it sweeps the state.
    localparam int unsigned DRAIN_CYCLES = 2600;
    localparam int unsigned DRAIN_LIMIT  = 20000;

    // Predicts the numbers that the generator returns and holds them until
    // the matching output transaction arrives.
    class number_tracker;
        bit [31:0]               words [mtg_pkg::STATE_WORDS];
        bit [mtg_pkg::POS_W-1:0] pos;
        bit [31:0]               due_numbers [$];
        int unsigned             mismatches;

        function new();
            pos        = mtg_pkg::POS_NEVER;
            mismatches = 0;
            foreach (words[k]) words[k] = '0;
        endfunction

        // Each word takes the upper halves of two successive LCG values.
        function void seed_words(bit [31:0] s);
            bit [31:0] w;
            for (int k = 0; k < mtg_pkg::STATE_WORDS; k++) begin
                w = s & HALF_MASK;
                s = s * mtg_pkg::LCG_MUL + 32'd1;
                w = w | ((s & HALF_MASK) >> 16);
                s = s * mtg_pkg::LCG_MUL + 32'd1;
                words[k] = w;
            end
            pos = mtg_pkg::POS_PENDING;
        endfunction

        // In-place twist: words already renewed feed the later ones.
        function void twist_words();
            int unsigned nxt;
            int unsigned far;
            bit [31:0]   y;
            for (int k = 0; k < mtg_pkg::STATE_WORDS; k++) begin
                nxt = (k + 1) % mtg_pkg::STATE_WORDS;
                far = (k + mtg_pkg::MID_DIST) % mtg_pkg::STATE_WORDS;
                y = (words[k] & HI_BIT) | (words[nxt] & LO_BITS);
                words[k] = words[far] ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_MAT : 32'd0);
            end
            pos = '0;
        endfunction

        function bit [31:0] temper(bit [31:0] y);
            y = y ^ (y >> 11);
            y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
            y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
            y = y ^ (y >> 18);
            return y;
        endfunction

        function void take_command(mtg_pkg::t_cmd cmd, bit [31:0] value, bit [9:0] idx);
            case (cmd)
                mtg_pkg::CMD_NEXT: begin
                    if (pos >= mtg_pkg::POS_PENDING) begin
                        if (pos == mtg_pkg::POS_NEVER) seed_words(mtg_pkg::DEFAULT_SEED);
                        twist_words();
                    end
                    due_numbers.push_back(temper(words[pos]));
                    pos = pos + 1'b1;
                end
                mtg_pkg::CMD_SEED: begin
                    seed_words(value);
                end
                mtg_pkg::CMD_LOAD: begin
                    if (idx < mtg_pkg::STATE_WORDS) begin
                        words[idx] = value;
                        pos        = mtg_pkg::POS_PENDING;
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check_number(bit [31:0] got);
            bit [31:0] want;
            if (due_numbers.size() == 0) begin
                $error("number: no result expected, actual %08h", got);
                mismatches++;
            end else begin
                want = due_numbers.pop_front();
                if (got !== want) begin
                    $error("number: expected %08h, actual %08h", want, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_cmd;
    logic [31:0] i_value;
    logic [9:0]  i_word_index;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_number;

    number_tracker board;
    // While set, neither side inserts idle cycles.
    bit            calm;

    mersenne_twister_generator u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_value      (i_value),
        .i_word_index (i_word_index),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_number     (o_number)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #36_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Output side: each number is checked on the edge where the transaction
    // completes, and ready is then redrawn for the next cycle. Values read
    // straight after the edge are those from before it, so the check does
    // not race the block's own registers.
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) board.check_number(o_number);
            if (calm) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Offers one command, possibly after a few idle cycles, and returns on
    // the edge at which the transaction is accepted. Valid is lowered only
    // in the idle cycles, so a back-to-back command keeps it high throughout.
    task automatic send_command(mtg_pkg::t_cmd cmd, logic [31:0] value, logic [9:0] idx);
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_value      <= value;
        i_word_index <= idx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.take_command(cmd, value, idx);
    endtask

    // Seeds and loaded words lean towards the all-zero and all-one patterns.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned counted;
        int unsigned seq_no;
        int unsigned kind;
        int unsigned run_len;
        int unsigned waited;
        logic [9:0]  idx;

        board        = new();
        calm         = 1'b0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_cmd        <= mtg_pkg::CMD_NEXT;
        i_value      <= '0;
        i_word_index <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Commands that are ignored come first, so that the
        // first number still finds the block never seeded and it seeds
        // itself with the default value. From then on every word is defined.
        send_command(mtg_pkg::CMD_NONE, 32'hffff_ffff, 10'h3ff);
        send_command(mtg_pkg::CMD_LOAD, 32'h1234_5678, 10'd1023);
        send_command(mtg_pkg::CMD_LOAD, 32'hffff_ffff, 10'(mtg_pkg::STATE_WORDS));
        repeat (3) send_command(mtg_pkg::CMD_NEXT, 32'h0, 10'h0);
        send_command(mtg_pkg::CMD_SEED, 32'h0000_0000, 10'h3ff);
        repeat (2) send_command(mtg_pkg::CMD_NEXT, 32'hffff_ffff, 10'h3ff);
        send_command(mtg_pkg::CMD_SEED, 32'hffff_ffff, 10'h0);
        send_command(mtg_pkg::CMD_NEXT, 32'h0, 10'h0);
        // Loads at both ends and at the middle distance, then a twist.
        send_command(mtg_pkg::CMD_LOAD, 32'hffff_ffff, 10'd0);
        send_command(mtg_pkg::CMD_LOAD, 32'h0000_0000, 10'(mtg_pkg::LAST_WORD));
        send_command(mtg_pkg::CMD_LOAD, 32'h8000_0000, 10'(mtg_pkg::MID_DIST));
        repeat (2) send_command(mtg_pkg::CMD_NEXT, 32'h0, 10'h0);
        send_command(mtg_pkg::CMD_SEED, mtg_pkg::DEFAULT_SEED, 10'h0);
        send_command(mtg_pkg::CMD_NEXT, 32'h0, 10'h0);
        send_command(mtg_pkg::CMD_LOAD, 32'h7fff_ffff, 10'd511);
        send_command(mtg_pkg::CMD_NEXT, 32'h0, 10'h0);
        send_command(mtg_pkg::CMD_NONE, 32'h0, 10'h0);
        send_command(mtg_pkg::CMD_NEXT, 32'h0, 10'h0);

        // Random part, built from short sequences. The first is a run long
        // enough to wrap the position and force a twist of its own accord.
        // Ignored commands are sent as noise and are not counted.
        counted = 0;
        seq_no  = 0;
        while (counted < RANDOM_ITEMS) begin
            calm = (counted >= 900 && counted < 1200);
            kind = (seq_no == 0) ? 0 : $urandom_range(99);
            if (kind < 60) begin
                run_len = (seq_no == 0) ? 650 : $urandom_range(40, 5);
                repeat (run_len) begin
                    send_command(mtg_pkg::CMD_NEXT, $urandom,
                                 10'($urandom_range(1023)));
                end
                counted += run_len;
            end else if (kind < 75) begin
                run_len = $urandom_range(6, 1);
                repeat (run_len) begin
                    case ($urandom_range(9))
                        0: idx = '0;
                        1: idx = mtg_pkg::LAST_WORD;
                        default: idx = 10'($urandom_range(mtg_pkg::STATE_WORDS - 1));
                    endcase
                    send_command(mtg_pkg::CMD_LOAD, pick_word(), idx);
                end
                counted += run_len;
            end else if (kind < 85) begin
                send_command(mtg_pkg::CMD_SEED, pick_word(), 10'($urandom_range(1023)));
                counted++;
            end else begin
                repeat ($urandom_range(3, 1)) begin
                    if ($urandom_range(1)) begin
                        send_command(mtg_pkg::CMD_NONE, $urandom,
                                     10'($urandom_range(1023)));
                    end else begin
                        send_command(mtg_pkg::CMD_LOAD, $urandom,
                                     10'($urandom_range(1023, mtg_pkg::STATE_WORDS)));
                    end
                end
            end
            seq_no++;
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        // Let the outstanding numbers drain, then watch for strays.
        waited = 0;
        while (board.due_numbers.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.due_numbers.size() != 0) begin
            $error("number: %0d expected results never arrived",
                   board.due_numbers.size());
        end
        if (board.mismatches == 0 && board.due_numbers.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/mtg_pkg.sv
rtl/core/mtg_ctrl.sv
rtl/core/mtg_dpath.sv
rtl/core/mersenne_twister_generator.sv
tb/mersenne_twister_generator_tb.sv
